// ===== sv/fts_pkg.sv =====
// fts_pkg: widths, constants and shared types of the tanh waveshaper.
// Used by fast_tanh_waveshaper and fts_checker; depends on nothing.
package fts_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int GAIN_BITS   = 16;
   localparam int GAIN_FRAC   = 8;

   localparam int PROD_BITS = SAMPLE_BITS - 1 + GAIN_BITS;
   localparam int AX_SHIFT  = SAMPLE_BITS - 1 + GAIN_FRAC - FRAC_BITS;
   localparam int AX_BITS   = FRAC_BITS + 6;
   localparam int X2_BITS   = FRAC_BITS + 11;
   localparam int X3_BITS   = FRAC_BITS + 16;
   localparam int X4_BITS   = FRAC_BITS + 21;
   localparam int COEF_BITS = FRAC_BITS;
   localparam int TA_BITS   = X3_BITS - 1;
   localparam int TB_BITS   = X4_BITS - 2;
   localparam int LIN_BITS  = X2_BITS + 1;
   localparam int DEN_BITS  = TB_BITS + 1;
   localparam int QUO_BITS  = FRAC_BITS + 1;
   localparam int WIDE_BITS = DEN_BITS + QUO_BITS;
   localparam int T_BITS    = FRAC_BITS + 1;
   localparam int CORR_BITS = FRAC_BITS + 9;
   localparam int YP_BITS   = T_BITS + CORR_BITS;
   localparam int OUT_SHIFT = 2 * FRAC_BITS - (SAMPLE_BITS - 1);
   localparam int YM_BITS   = YP_BITS + 1 - OUT_SHIFT;
   localparam int CDIV_BITS = 2 * FRAC_BITS + 1;
   localparam int CNT_BITS  = $clog2(CDIV_BITS);
   localparam int HALF_Q    = 1 << (FRAC_BITS - 1);

   // pipeline stages that carry the sideband: shape stages, divider steps, tanh stage
   localparam int SHAPE_STAGES = 6;
   localparam int SIDE_DEPTH   = SHAPE_STAGES + QUO_BITS + 1;
   localparam int T_STAGE      = SIDE_DEPTH - 1;

   localparam logic [GAIN_BITS-1:0]   PREGAIN_RESET = GAIN_BITS'(256);
   localparam logic [SAMPLE_BITS-1:0] SIGN_BIT      = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX    = SIGN_BIT - SAMPLE_BITS'(1);
   localparam logic [AX_BITS-1:0]     AX_CLAMP      = AX_BITS'(32) << FRAC_BITS;
   localparam logic [T_BITS-1:0]      ONE_Q         = T_BITS'(1) << FRAC_BITS;
   localparam logic [DEN_BITS-1:0]    RECIP_ONE     = DEN_BITS'(1) << (2 * FRAC_BITS);
   localparam logic [CDIV_BITS-1:0]   CORR_ONE      = CDIV_BITS'(1) << (2 * FRAC_BITS);
   localparam logic [CORR_BITS-1:0]   CORR_MAX      = '1;

   localparam logic [63:0] COEF_A32 = 64'd2852821101;
   localparam logic [63:0] COEF_B32 = 64'd1566945177;
   localparam logic [COEF_BITS-1:0] COEF_A =
      COEF_BITS'((COEF_A32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam logic [COEF_BITS-1:0] COEF_B =
      COEF_BITS'((COEF_B32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_LAUNCH,
      CS_SHAPE,
      CS_DIVIDE
   } corr_state_type;

   typedef struct packed {
      logic vld;
      logic cfg;
      logic neg;
   } side_type;

endpackage

// ===== sv/fast_tanh_waveshaper.sv =====
// fast_tanh_waveshaper: pipelined rational-tanh soft clipper; depends on fts_pkg.
// Throughput one item per cycle while results are taken and no correction pass runs.
// The whole pipeline holds while a result waits on rsp_ready.
// Reset: pipeline empty, pregain 256; then a correction pass (shape pass through the
// pipeline plus a 33-step serial divide) with req_ready low.
// Each pregain write starts the same pass, once any earlier correction item has drained.
module fast_tanh_waveshaper (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [fts_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fts_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                                   csr_wr_en,
   input  logic [fts_pkg::GAIN_BITS-1:0]          csr_wr_data
);

   localparam int SB = fts_pkg::SAMPLE_BITS;
   localparam int FB = fts_pkg::FRAC_BITS;

   // control
   logic                    advance;
   logic                    accept;
   logic                    launch;
   logic                    cfg_busy;
   fts_pkg::corr_state_type state_ff, state_in;
   logic [fts_pkg::GAIN_BITS-1:0] pregain_ff, pregain_in;
   logic [fts_pkg::CORR_BITS-1:0] gc_ff, gc_in;

   // serial correction divider
   logic [fts_pkg::T_BITS-1:0]    cd_rem_ff, cd_rem_in;
   logic [fts_pkg::CDIV_BITS-1:0] cd_quo_ff, cd_quo_in;
   logic [fts_pkg::T_BITS-1:0]    cd_den_ff, cd_den_in;
   logic [fts_pkg::CNT_BITS-1:0]  cd_cnt_ff, cd_cnt_in;
   logic [fts_pkg::T_BITS:0]      cd_trial;
   logic [fts_pkg::T_BITS-1:0]    cd_rem_next;
   logic                          cd_fit;
   logic [fts_pkg::CDIV_BITS-1:0] cd_quo_next;

   // sideband shift line
   fts_pkg::side_type side_ff [fts_pkg::SIDE_DEPTH];
   fts_pkg::side_type side_in;

   // stage 1
   logic [SB-1:0]                 raw;
   logic                          neg;
   logic [SB-1:0]                 mag;
   logic [fts_pkg::PROD_BITS-1:0] prod_full;
   logic [fts_pkg::PROD_BITS-1:0] s1_prod_ff;

   // stage 2
   logic [fts_pkg::PROD_BITS:0]   ax_sum;
   logic [fts_pkg::PROD_BITS:0]   ax_full;
   logic [fts_pkg::AX_BITS-1:0]   s2_ax_ff, s2_ax_in;

   // stage 3
   logic [2*fts_pkg::AX_BITS-1:0] sq_prod;
   logic [fts_pkg::AX_BITS-1:0]   s3_ax_ff;
   logic [fts_pkg::X2_BITS-1:0]   s3_x2_ff;

   // stage 4
   logic [fts_pkg::X2_BITS+fts_pkg::AX_BITS-1:0] cube_prod;
   logic [2*fts_pkg::X2_BITS-1:0]                quart_prod;
   logic [fts_pkg::AX_BITS-1:0]                  s4_ax_ff;
   logic [fts_pkg::X2_BITS-1:0]                  s4_x2_ff;
   logic [fts_pkg::X3_BITS-1:0]                  s4_x3_ff;
   logic [fts_pkg::X4_BITS-1:0]                  s4_x4_ff;

   // stage 5
   logic [fts_pkg::X3_BITS+fts_pkg::COEF_BITS-1:0] ta_prod;
   logic [fts_pkg::X4_BITS+fts_pkg::COEF_BITS-1:0] tb_prod;
   logic [fts_pkg::LIN_BITS-1:0]                   s5_lin_ff;
   logic [fts_pkg::TA_BITS-1:0]                    s5_ta_ff;
   logic [fts_pkg::TB_BITS-1:0]                    s5_tb_ff;

   // stage 6
   logic [fts_pkg::DEN_BITS-1:0] s6_den_ff;

   // reciprocal divider, one quotient bit per stage
   logic [fts_pkg::DEN_BITS-1:0]  dv_den_src [fts_pkg::QUO_BITS];
   logic [fts_pkg::DEN_BITS-1:0]  dv_rem_src [fts_pkg::QUO_BITS];
   logic [fts_pkg::QUO_BITS-1:0]  dv_quo_src [fts_pkg::QUO_BITS];
   logic [fts_pkg::WIDE_BITS-1:0] dv_sub     [fts_pkg::QUO_BITS];
   logic [fts_pkg::DEN_BITS-1:0]  dv_rem_in  [fts_pkg::QUO_BITS];
   logic [fts_pkg::QUO_BITS-1:0]  dv_quo_in  [fts_pkg::QUO_BITS];
   logic [fts_pkg::DEN_BITS-1:0]  dv_den_ff  [fts_pkg::QUO_BITS];
   logic [fts_pkg::DEN_BITS-1:0]  dv_rem_ff  [fts_pkg::QUO_BITS];
   logic [fts_pkg::QUO_BITS-1:0]  dv_quo_ff  [fts_pkg::QUO_BITS];

   // tanh, gain and output stages
   logic [fts_pkg::QUO_BITS-1:0] quo_last;
   logic [fts_pkg::T_BITS-1:0]   t_ff, t_in;
   logic                         m_vld_ff;
   logic                         m_neg_ff;
   logic [fts_pkg::YP_BITS-1:0]  m_yp_ff;
   logic [fts_pkg::YP_BITS:0]    y_sum;
   logic [fts_pkg::YM_BITS-1:0]  y_mag;
   logic [SB-1:0]                y_lim;
   logic                         rsp_valid_ff;
   logic [SB-1:0]                rsp_sample_out_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && (state_ff == fts_pkg::CS_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_busy = 1'b0;
      for (int j = 0; j < fts_pkg::SIDE_DEPTH; j++) begin
         cfg_busy = cfg_busy | (side_ff[j].vld & side_ff[j].cfg);
      end
   end

   // ---------------------------------------------------------------- correction control
   always_comb begin
      state_in   = state_ff;
      launch     = 1'b0;
      pregain_in = pregain_ff;
      gc_in      = gc_ff;
      cd_rem_in  = cd_rem_ff;
      cd_quo_in  = cd_quo_ff;
      cd_den_in  = cd_den_ff;
      cd_cnt_in  = cd_cnt_ff;

      cd_trial    = {cd_rem_ff, cd_quo_ff[fts_pkg::CDIV_BITS-1]};
      cd_fit      = cd_trial >= (fts_pkg::T_BITS+1)'(cd_den_ff);
      cd_rem_next = cd_fit ? fts_pkg::T_BITS'(cd_trial - (fts_pkg::T_BITS+1)'(cd_den_ff))
                           : fts_pkg::T_BITS'(cd_trial);
      cd_quo_next = {cd_quo_ff[fts_pkg::CDIV_BITS-2:0], cd_fit};

      unique case (state_ff)
         fts_pkg::CS_IDLE: begin
         end
         fts_pkg::CS_LAUNCH: begin
            if (advance && !cfg_busy) begin
               launch   = 1'b1;
               state_in = fts_pkg::CS_SHAPE;
            end
         end
         fts_pkg::CS_SHAPE: begin
            if (side_ff[fts_pkg::T_STAGE].vld && side_ff[fts_pkg::T_STAGE].cfg) begin
               if (t_ff == '0) begin
                  gc_in    = fts_pkg::CORR_MAX;
                  state_in = fts_pkg::CS_IDLE;
               end else begin
                  cd_rem_in = '0;
                  cd_quo_in = fts_pkg::CORR_ONE + fts_pkg::CDIV_BITS'(t_ff >> 1);
                  cd_den_in = t_ff;
                  cd_cnt_in = fts_pkg::CNT_BITS'(fts_pkg::CDIV_BITS - 1);
                  state_in  = fts_pkg::CS_DIVIDE;
               end
            end
         end
         fts_pkg::CS_DIVIDE: begin
            cd_rem_in = cd_rem_next;
            cd_quo_in = cd_quo_next;
            cd_cnt_in = cd_cnt_ff - fts_pkg::CNT_BITS'(1);
            if (cd_cnt_ff == '0) begin
               gc_in    = (cd_quo_next > fts_pkg::CDIV_BITS'(fts_pkg::CORR_MAX)) ?
                          fts_pkg::CORR_MAX : cd_quo_next[fts_pkg::CORR_BITS-1:0];
               state_in = fts_pkg::CS_IDLE;
            end
         end
      endcase

      if (csr_wr_en) begin
         pregain_in = csr_wr_data;
         state_in   = fts_pkg::CS_LAUNCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fts_pkg::CS_LAUNCH;
         pregain_ff <= fts_pkg::PREGAIN_RESET;
      end else begin
         state_ff   <= state_in;
         pregain_ff <= pregain_in;
      end
   end

   always_ff @(posedge clock) begin
      gc_ff     <= gc_in;
      cd_rem_ff <= cd_rem_in;
      cd_quo_ff <= cd_quo_in;
      cd_den_ff <= cd_den_in;
      cd_cnt_ff <= cd_cnt_in;
   end

   // ---------------------------------------------------------------- shape stages
   assign raw       = req_sample_in;
   assign neg       = raw[SB-1];
   assign mag       = launch ? fts_pkg::SIGN_BIT : (neg ? (~raw + SB'(1)) : raw);
   assign prod_full = fts_pkg::PROD_BITS'(mag) * fts_pkg::PROD_BITS'(pregain_ff);

   assign side_in.vld = accept || launch;
   assign side_in.cfg = launch;
   assign side_in.neg = neg;

   assign ax_sum   = (fts_pkg::PROD_BITS+1)'(s1_prod_ff)
                   + (fts_pkg::PROD_BITS+1)'(1 << (fts_pkg::AX_SHIFT - 1));
   assign ax_full  = ax_sum >> fts_pkg::AX_SHIFT;
   assign s2_ax_in = (ax_full > (fts_pkg::PROD_BITS+1)'(fts_pkg::AX_CLAMP)) ?
                     fts_pkg::AX_CLAMP : ax_full[fts_pkg::AX_BITS-1:0];

   assign sq_prod    = (2*fts_pkg::AX_BITS)'(s2_ax_ff) * (2*fts_pkg::AX_BITS)'(s2_ax_ff)
                     + (2*fts_pkg::AX_BITS)'(fts_pkg::HALF_Q);
   assign cube_prod  = (fts_pkg::X2_BITS+fts_pkg::AX_BITS)'(s3_x2_ff)
                     * (fts_pkg::X2_BITS+fts_pkg::AX_BITS)'(s3_ax_ff)
                     + (fts_pkg::X2_BITS+fts_pkg::AX_BITS)'(fts_pkg::HALF_Q);
   assign quart_prod = (2*fts_pkg::X2_BITS)'(s3_x2_ff) * (2*fts_pkg::X2_BITS)'(s3_x2_ff)
                     + (2*fts_pkg::X2_BITS)'(fts_pkg::HALF_Q);
   assign ta_prod    = (fts_pkg::X3_BITS+fts_pkg::COEF_BITS)'(s4_x3_ff)
                     * (fts_pkg::X3_BITS+fts_pkg::COEF_BITS)'(fts_pkg::COEF_A)
                     + (fts_pkg::X3_BITS+fts_pkg::COEF_BITS)'(fts_pkg::HALF_Q);
   assign tb_prod    = (fts_pkg::X4_BITS+fts_pkg::COEF_BITS)'(s4_x4_ff)
                     * (fts_pkg::X4_BITS+fts_pkg::COEF_BITS)'(fts_pkg::COEF_B)
                     + (fts_pkg::X4_BITS+fts_pkg::COEF_BITS)'(fts_pkg::HALF_Q);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= prod_full;
         s2_ax_ff   <= s2_ax_in;
         s3_ax_ff   <= s2_ax_ff;
         s3_x2_ff   <= sq_prod[FB +: fts_pkg::X2_BITS];
         s4_ax_ff   <= s3_ax_ff;
         s4_x2_ff   <= s3_x2_ff;
         s4_x3_ff   <= cube_prod[FB +: fts_pkg::X3_BITS];
         s4_x4_ff   <= quart_prod[FB +: fts_pkg::X4_BITS];
         s5_lin_ff  <= fts_pkg::LIN_BITS'(fts_pkg::ONE_Q) + fts_pkg::LIN_BITS'(s4_ax_ff)
                     + fts_pkg::LIN_BITS'(s4_x2_ff);
         s5_ta_ff   <= ta_prod[FB +: fts_pkg::TA_BITS];
         s5_tb_ff   <= tb_prod[FB +: fts_pkg::TB_BITS];
         s6_den_ff  <= fts_pkg::DEN_BITS'(s5_lin_ff) + fts_pkg::DEN_BITS'(s5_ta_ff)
                     + fts_pkg::DEN_BITS'(s5_tb_ff);
      end
   end

   // ---------------------------------------------------------------- reciprocal divider
   always_comb begin
      dv_den_src[0] = s6_den_ff;
      dv_rem_src[0] = fts_pkg::RECIP_ONE + (s6_den_ff >> 1);
      dv_quo_src[0] = '0;
      for (int k = 1; k < fts_pkg::QUO_BITS; k++) begin
         dv_den_src[k] = dv_den_ff[k-1];
         dv_rem_src[k] = dv_rem_ff[k-1];
         dv_quo_src[k] = dv_quo_ff[k-1];
      end
      for (int k = 0; k < fts_pkg::QUO_BITS; k++) begin
         dv_sub[k] = fts_pkg::WIDE_BITS'(dv_den_src[k]) << (fts_pkg::QUO_BITS - 1 - k);
         if (fts_pkg::WIDE_BITS'(dv_rem_src[k]) >= dv_sub[k]) begin
            dv_rem_in[k] = dv_rem_src[k] - dv_sub[k][fts_pkg::DEN_BITS-1:0];
            dv_quo_in[k] = dv_quo_src[k]
                         | (fts_pkg::QUO_BITS'(1) << (fts_pkg::QUO_BITS - 1 - k));
         end else begin
            dv_rem_in[k] = dv_rem_src[k];
            dv_quo_in[k] = dv_quo_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < fts_pkg::QUO_BITS; k++) begin
            dv_den_ff[k] <= dv_den_src[k];
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_quo_ff[k] <= dv_quo_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- tanh, gain, output
   assign quo_last = dv_quo_ff[fts_pkg::QUO_BITS-1];
   assign t_in     = (quo_last >= fts_pkg::ONE_Q) ? '0 : fts_pkg::ONE_Q - quo_last;

   assign y_sum = (fts_pkg::YP_BITS+1)'(m_yp_ff)
                + (fts_pkg::YP_BITS+1)'(1 << (fts_pkg::OUT_SHIFT - 1));
   assign y_mag = y_sum[fts_pkg::OUT_SHIFT +: fts_pkg::YM_BITS];
   assign y_lim = (y_mag > fts_pkg::YM_BITS'(fts_pkg::SAMPLE_MAX)) ?
                  fts_pkg::SAMPLE_MAX : y_mag[SB-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff              <= t_in;
         m_neg_ff          <= side_ff[fts_pkg::T_STAGE].neg;
         m_yp_ff           <= fts_pkg::YP_BITS'(t_ff) * fts_pkg::YP_BITS'(gc_ff);
         rsp_sample_out_ff <= m_neg_ff ? (~y_lim + SB'(1)) : y_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < fts_pkg::SIDE_DEPTH; j++) begin
            side_ff[j] <= '0;
         end
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         side_ff[0] <= side_in;
         for (int j = 1; j < fts_pkg::SIDE_DEPTH; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         // drop the correction token before the gain stage
         m_vld_ff     <= side_ff[fts_pkg::T_STAGE].vld && !side_ff[fts_pkg::T_STAGE].cfg;
         rsp_valid_ff <= m_vld_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

endmodule

// ===== sv/fts_checker.sv =====
// fts_checker: port-level checks of fast_tanh_waveshaper, bound to the top level.
// Depends on fts_pkg and on the top level's port names.
module fts_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [fts_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                                   csr_wr_en
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the item was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out))
      else $error("rsp_sample_out changed while stalled");

   a_no_min_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_out != $signed(fts_pkg::SIGN_BIT))
      else $error("output not saturated symmetrically");

   a_ready_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_ready)
      else $error("input taken while gain correction is recomputed");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("input taken before the reset correction pass");

endmodule

bind fast_tanh_waveshaper fts_checker u_fts_checker (.*);

// ===== verif/tb_fast_tanh_waveshaper.sv =====
// Testbench for fast_tanh_waveshaper: streams Q1.15 samples through the soft clipper under
// several pregain settings and idle patterns, checking each output against a local predictor.
// Depends on fts_pkg and the fast_tanh_waveshaper RTL.
module tb_fast_tanh_waveshaper;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB = fts_pkg::SAMPLE_BITS;
   localparam int FB = fts_pkg::FRAC_BITS;
   localparam int GB = fts_pkg::GAIN_BITS;
   localparam int CB = fts_pkg::CORR_BITS;
   localparam int DRIVE_SHIFT = SB - 1 + 8 - FB;
   localparam int SCALE_SHIFT = 2 * FB - (SB - 1);
   localparam longint unsigned Q_UNIT = 64'd1 << FB;
   localparam longint unsigned MAG_CLAMP = 64'd32 << FB;
   localparam longint unsigned COEF_CUBE = (64'd2852821101 + (64'd1 << (31 - FB))) >> (32 - FB);
   localparam longint unsigned COEF_QUART = (64'd1566945177 + (64'd1 << (31 - FB))) >> (32 - FB);
   localparam longint unsigned CORR_TOP = (64'd1 << CB) - 1;
   localparam longint unsigned OUT_TOP = (64'd1 << (SB - 1)) - 1;
   localparam int RANDOM_PER_PHASE = 135;
   localparam int NUM_PHASES = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [SB-1:0] req_sample_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_sample_out;
   logic                 csr_wr_en = 1'b0;
   logic [GB-1:0]        csr_wr_data = '0;

   logic signed [SB-1:0] samples_to_send[$];
   logic signed [SB-1:0] shaped_expected[$];
   logic [GB-1:0]        drive_gain = fts_pkg::PREGAIN_RESET;
   logic [CB-1:0]        gain_corr;
   logic                 took_item = 1'b0;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   hold_requests = 0;
   int                   holds_served = 0;
   int                   hold_left = 0;
   int                   error_count = 0;
   int                   items_sent = 0;
   int                   results_seen = 0;
   int                   cycle_count = 0;

   fast_tanh_waveshaper i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic longint unsigned mul_round(longint unsigned p, longint unsigned q);
      return (p >> FB) * q + (((p & (Q_UNIT - 1)) * q + (Q_UNIT >> 1)) >> FB);
   endfunction

   function automatic longint unsigned tanh_mag(longint unsigned mag);
      longint unsigned ax, x2, x3, x4, den, rec;
      ax = (mag > MAG_CLAMP) ? MAG_CLAMP : mag;
      x2 = mul_round(ax, ax);
      x3 = mul_round(x2, ax);
      x4 = mul_round(x2, x2);
      den = Q_UNIT + ax + x2 + mul_round(x3, COEF_CUBE) + mul_round(x4, COEF_QUART);
      rec = ((64'd1 << (2 * FB)) + (den >> 1)) / den;
      if (rec > Q_UNIT) begin
         rec = Q_UNIT;
      end
      return Q_UNIT - rec;
   endfunction

   function automatic logic [CB-1:0] correction_for(logic [GB-1:0] gain);
      longint unsigned t, c;
      t = tanh_mag(64'(gain) << (FB - 8));
      if (t == 0) begin
         return CB'(CORR_TOP);
      end
      c = ((64'd1 << (2 * FB)) + (t >> 1)) / t;
      return CB'((c > CORR_TOP) ? CORR_TOP : c);
   endfunction

   function automatic logic signed [SB-1:0] shape_sample(logic signed [SB-1:0] din);
      logic [SB-1:0]   raw;
      logic            neg;
      longint unsigned mag, y;
      raw = din;
      neg = raw[SB-1];
      mag = neg ? ((64'd1 << SB) - 64'(raw)) : 64'(raw);
      mag = (mag * 64'(drive_gain) + (64'd1 << (DRIVE_SHIFT - 1))) >> DRIVE_SHIFT;
      y = tanh_mag(mag) * 64'(gain_corr);
      y = (y + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
      if (y > OUT_TOP) begin
         y = OUT_TOP;
      end
      return SB'(neg ? (64'd0 - y) : y);
   endfunction

   // driver: record accepted items at the rising edge, offer the next at the falling edge
   always @(posedge clock) begin
      took_item <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         shaped_expected.push_back(shape_sample(req_sample_in));
         items_sent++;
      end
   end

   always @(negedge clock) begin
      if (!req_valid || took_item) begin
         if (!reset && samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_sample_in <= samples_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (shaped_expected.size() == 0) begin
            $error("sample_out: no item pending, got %0d", rsp_sample_out);
            error_count++;
         end else if (rsp_sample_out !== shaped_expected[0]) begin
            $error("sample_out: expected %0d, got %0d", shaped_expected[0], rsp_sample_out);
            error_count++;
            void'(shaped_expected.pop_front());
         end else begin
            void'(shaped_expected.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_pregain(input logic [GB-1:0] value);
      while (req_ready !== 1'b1) begin
         @(negedge clock);
      end
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      drive_gain = value;
      gain_corr = correction_for(value);
   endtask

   task automatic drain();
      do begin
         @(negedge clock);
      end while (samples_to_send.size() != 0 || req_valid || shaped_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [GB-1:0]        gain;
      logic signed [SB-1:0] smp;
      gain_corr = correction_for(drive_gain);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      samples_to_send = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd16384,
                          -16'sd16384, 16'sd256, -16'sd256, 16'sh5555, 16'shAAAA, 16'sd8,
                          -16'sd8, 16'sd4096};
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: gain = 16'hFFFF;
               2: gain = 16'd1;
               3: gain = 16'd0;
               4: gain = 16'd2048;
               5: gain = 16'd64;
               6: gain = 16'd512;
               8: gain = GB'($urandom_range(1, 1024));
               9: gain = GB'($urandom_range(128, 4096));
               11: gain = 16'd300;
               default: gain = GB'($urandom_range(1, 65535));
            endcase
            write_pregain(gain);
         end
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (phase == NUM_PHASES - 1) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_requests++;
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            case ($urandom_range(3))
               0: smp = SB'($urandom);
               1: smp = SB'($urandom_range(0, 255));
               2: smp = SB'($urandom_range(0, 4095));
               default: smp = $urandom_range(1) ? 16'sd32767 - SB'($urandom_range(0, 3))
                                                : -16'sd32768 + SB'($urandom_range(0, 3));
            endcase
            if (smp != 0 && $urandom_range(1)) begin
               smp = -smp;
            end
            samples_to_send.push_back(smp);
         end
         drain();
      end

      error_count += shaped_expected.size();
      $display("Shaped %0d samples (%0d results) over %0d drive settings, zero and full gain",
               items_sent, results_seen, NUM_PHASES);
      $display("included, with sender gaps, receiver stalls and a long output hold-off.");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
